@@ rtl/chist_pkg.sv @@
// Shared types and constants for the channel histogram block.
// Used by the controller, the datapath and the top level; depends on nothing.
package chist_pkg;

  localparam int NUM_BINS = 256;
  localparam int BIN_AW   = $clog2(NUM_BINS);
  localparam int PIX_W    = 8;
  localparam int OUT_CW   = 32;              // width of the count output ports
  localparam int QUOT_W   = 16;              // Q0.16 fraction bits
  localparam int NORM_W   = QUOT_W + 1;      // fraction plus the "equals one" bit
  localparam int STEP_W   = $clog2(QUOT_W);
  localparam int LUMA_W   = 2 * PIX_W + PIX_W; // 16-bit weights times 8-bit pixels

  localparam logic [QUOT_W-1:0] W_RED   = 16'd19595;
  localparam logic [QUOT_W-1:0] W_GREEN = 16'd38470;
  localparam logic [QUOT_W-1:0] W_BLUE  = 16'd7471;

  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << QUOT_W;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CH_LUMA  = 2'd0,
    CH_RED   = 2'd1,
    CH_GREEN = 2'd2,
    CH_BLUE  = 2'd3
  } chan_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INDEX  = 6'b000010,
    S_READ   = 6'b000100,
    S_UPDATE = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  typedef struct packed {
    logic capture;     // latch the input beat
    logic clear;       // drop all bins and the peak
    logic calc_index;  // work out the bin of the latched pixel
    logic ram_read;    // read the selected bin
    logic accumulate;  // write back the incremented count
    logic load_div;    // start the normalising divide
    logic div_step;    // one quotient bit
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;        // latched op code
    logic       div_skip;  // peak zero or count not below peak
    logic       div_last;  // final quotient bit this cycle
  } status_t;

endpackage

@@ rtl/chist_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module chist_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/chist_ctrl.sv @@
// Sequencer for the histogram: decodes the op and steps the datapath.
// Uses chist_pkg for the state, op codes and command/status structs.
module chist_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          op_i,
  input  chist_pkg::status_t  status_i,
  output chist_pkg::cmd_t     cmd_o,
  output logic                busy,
  output logic                result_valid_o
);

  chist_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      chist_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          case (op_i)
            chist_pkg::OP_CLEAR: cmd_o.clear = 1'b1;
            chist_pkg::OP_ACCUM: state_d = chist_pkg::S_INDEX;
            chist_pkg::OP_READ:  state_d = chist_pkg::S_READ;
            default:             state_d = chist_pkg::S_IDLE;
          endcase
        end
      end
      chist_pkg::S_INDEX: begin
        cmd_o.calc_index = 1'b1;
        state_d          = chist_pkg::S_READ;
      end
      chist_pkg::S_READ: begin
        cmd_o.ram_read = 1'b1;
        state_d        = chist_pkg::S_UPDATE;
      end
      chist_pkg::S_UPDATE: begin
        if (status_i.op == chist_pkg::OP_READ) begin
          cmd_o.load_div = 1'b1;
          state_d = status_i.div_skip ? chist_pkg::S_DONE : chist_pkg::S_DIV;
        end else begin
          cmd_o.accumulate = 1'b1;
          state_d          = chist_pkg::S_IDLE;
        end
      end
      chist_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = chist_pkg::S_DONE;
        end
      end
      chist_pkg::S_DONE: begin
        state_d = chist_pkg::S_IDLE;
      end
      default: begin
        state_d = chist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chist_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != chist_pkg::S_IDLE);
  assign result_valid_o = (state_q == chist_pkg::S_DONE);

endmodule

@@ rtl/chist_dpath.sv @@
// Histogram datapath: bin select, bin RAM with valid bits, peak and divider.
// Uses chist_pkg and instantiates chist_ram.
module chist_dpath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  chist_pkg::cmd_t                   cmd_i,
  output chist_pkg::status_t                status_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i,
  input  logic [1:0]                        op_i,
  input  logic [chist_pkg::PIX_W-1:0]       pixel_red_i,
  input  logic [chist_pkg::PIX_W-1:0]       pixel_green_i,
  input  logic [chist_pkg::PIX_W-1:0]       pixel_blue_i,
  input  logic [chist_pkg::BIN_AW-1:0]      bin_index_i,
  output logic [chist_pkg::NORM_W-1:0]      norm_value_o,
  output logic [chist_pkg::OUT_CW-1:0]      bin_count_o,
  output logic [chist_pkg::OUT_CW-1:0]      peak_count_o
);

  localparam int WideW = (COUNT_WIDTH > chist_pkg::OUT_CW) ? COUNT_WIDTH : chist_pkg::OUT_CW;

  chist_pkg::chan_e                  chan_q;
  logic [1:0]                        op_q;
  logic [chist_pkg::PIX_W-1:0]       red_q, green_q, blue_q;
  logic [chist_pkg::BIN_AW-1:0]      idx_q, idx_d;
  logic [chist_pkg::NUM_BINS-1:0]    valid_q;
  logic                              vld_rd_q;
  logic [COUNT_WIDTH-1:0]            peak_q, cnt_q, rem_q;
  logic [chist_pkg::NORM_W-1:0]      quot_q;
  logic [chist_pkg::STEP_W-1:0]      step_q;

  logic [COUNT_WIDTH-1:0]            ram_rdata, cur_cnt, inc_cnt;
  logic [chist_pkg::LUMA_W-1:0]      luma_sum;
  logic [COUNT_WIDTH:0]              rem_sh, rem_sub;
  logic                              rem_ge;
  logic [WideW-1:0]                  cnt_wide, peak_wide;

  chist_ram #(
    .Width (COUNT_WIDTH),
    .Depth (chist_pkg::NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accumulate),
    .waddr_i (idx_q),
    .wdata_i (inc_cnt),
    .re_i    (cmd_i.ram_read),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // luma: Q0.16 weights sum to one, so the top byte is the bin
  assign luma_sum = chist_pkg::LUMA_W'(chist_pkg::W_RED)   * chist_pkg::LUMA_W'(red_q)
                  + chist_pkg::LUMA_W'(chist_pkg::W_GREEN) * chist_pkg::LUMA_W'(green_q)
                  + chist_pkg::LUMA_W'(chist_pkg::W_BLUE)  * chist_pkg::LUMA_W'(blue_q);

  always_comb begin
    case (chan_q)
      chist_pkg::CH_RED:   idx_d = red_q;
      chist_pkg::CH_GREEN: idx_d = green_q;
      chist_pkg::CH_BLUE:  idx_d = blue_q;
      default:             idx_d = luma_sum[chist_pkg::LUMA_W-1 -: chist_pkg::BIN_AW];
    endcase
  end

  // a bin not written since the last clear reads as zero
  assign cur_cnt = vld_rd_q ? ram_rdata : '0;
  assign inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

  // restoring divide, remainder always below the peak
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = (rem_sh >= {1'b0, peak_q});
  assign rem_sub = rem_sh - {1'b0, peak_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= chist_pkg::CH_LUMA;
      valid_q <= '0;
      peak_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        chan_q <= chist_pkg::chan_e'(cfg_wdata_i);
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
        peak_q  <= '0;
      end else if (cmd_i.accumulate) begin
        valid_q[idx_q] <= 1'b1;
        if (inc_cnt > peak_q) begin
          peak_q <= inc_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      red_q   <= pixel_red_i;
      green_q <= pixel_green_i;
      blue_q  <= pixel_blue_i;
      idx_q   <= bin_index_i;
    end else if (cmd_i.calc_index) begin
      idx_q <= idx_d;
    end
    if (cmd_i.ram_read) begin
      vld_rd_q <= valid_q[idx_q];
    end
    if (cmd_i.load_div) begin
      cnt_q  <= cur_cnt;
      rem_q  <= cur_cnt;
      step_q <= '0;
      quot_q <= (peak_q != '0 && cur_cnt >= peak_q) ? chist_pkg::NORM_ONE : '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? rem_sub[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
      quot_q <= {quot_q[chist_pkg::NORM_W-2:0], rem_ge};
      step_q <= step_q + chist_pkg::STEP_W'(1);
    end
  end

  assign status_o.op       = op_q;
  assign status_o.div_skip = (peak_q == '0) || (cur_cnt >= peak_q);
  assign status_o.div_last = (step_q == chist_pkg::STEP_W'(chist_pkg::QUOT_W - 1));

  assign cnt_wide     = WideW'(cnt_q);
  assign peak_wide    = WideW'(peak_q);
  assign bin_count_o  = cnt_wide[chist_pkg::OUT_CW-1:0];
  assign peak_count_o = peak_wide[chist_pkg::OUT_CW-1:0];
  assign norm_value_o = quot_q;

endmodule

@@ rtl/channel_histogram_normalized_unit.sv @@
// Top level of the 256-bin channel histogram with peak-normalised read-out.
// Uses chist_pkg; instantiates chist_ctrl and chist_dpath.
//
//   channel   handshake              payload
//   -------   --------------------   --------------------------------------------
//   command   start / busy           op_i, pixel_red/green/blue_i, bin_index_i
//   result    result_valid_o strobe  norm_value_o, bin_count_o, peak_count_o
//   config    cfg_we_i               cfg_wdata_i (channel select)
//
// A beat is taken when start is high and busy low. Clear (and the unused op)
// completes at that edge with busy staying low. Accumulate holds busy through
// bin select, RAM read and read-modify-write. Read holds busy through RAM
// read, bin check, the radix-2 divider with one step per quotient bit, then
// the result cycle; the divider is skipped when the peak is zero or the bin
// equals the peak.
// Reset clears the bin valid flags at once; no sweep. Results cannot be stalled.
module channel_histogram_normalized_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   op_i,
  input  logic [chist_pkg::PIX_W-1:0]  pixel_red_i,
  input  logic [chist_pkg::PIX_W-1:0]  pixel_green_i,
  input  logic [chist_pkg::PIX_W-1:0]  pixel_blue_i,
  input  logic [chist_pkg::BIN_AW-1:0] bin_index_i,
  output logic                         result_valid_o,
  output logic [chist_pkg::NORM_W-1:0] norm_value_o,
  output logic [chist_pkg::OUT_CW-1:0] bin_count_o,
  output logic [chist_pkg::OUT_CW-1:0] peak_count_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_wdata_i
);

  chist_pkg::cmd_t    cmd;
  chist_pkg::status_t status;

  chist_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .op_i           (op_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  chist_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .bin_index_i   (bin_index_i),
    .norm_value_o  (norm_value_o),
    .bin_count_o   (bin_count_o),
    .peak_count_o  (peak_count_o)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for channel_histogram_normalized_unit.
// Holds its own histogram predictor and checks every read-out beat against it.
// Depends on chist_pkg and the RTL of the block only.
module testbench;
  import chist_pkg::*;

  // counter width below OUT_CW, so the upper bits of the count ports read as zero
  localparam int COUNT_W   = 16;
  localparam int RAND_ITEMS = 1400;
  localparam int PHASES    = 7;
  localparam int DRAIN_CYC = 24;        // covers the longest busy stretch, a read with a divide
  localparam int LIMIT_CYC = 200_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [NORM_W-1:0] norm;
    logic [OUT_CW-1:0] count;
    logic [OUT_CW-1:0] peak;
  } bin_readout_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          op_i;
  logic [PIX_W-1:0]    pixel_red_i;
  logic [PIX_W-1:0]    pixel_green_i;
  logic [PIX_W-1:0]    pixel_blue_i;
  logic [BIN_AW-1:0]   bin_index_i;
  logic                result_valid_o;
  logic [NORM_W-1:0]   norm_value_o;
  logic [OUT_CW-1:0]   bin_count_o;
  logic [OUT_CW-1:0]   peak_count_o;
  logic                cfg_we_i;
  logic [1:0]          cfg_wdata_i;

  // predictor state
  logic [COUNT_W-1:0]  hist_bins [NUM_BINS];
  logic [COUNT_W-1:0]  hist_peak;
  chan_e               hist_chan;
  logic [BIN_AW-1:0]   last_bin;
  bin_readout_t        readouts_due [$];

  int  fail_count;
  bit  gaps_on;
  int  burst_left;

  channel_histogram_normalized_unit #(
    .COUNT_WIDTH (COUNT_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .bin_index_i    (bin_index_i),
    .result_valid_o (result_valid_o),
    .norm_value_o   (norm_value_o),
    .bin_count_o    (bin_count_o),
    .peak_count_o   (peak_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (LIMIT_CYC) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [OUT_CW-1:0] want,
                               input logic [OUT_CW-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endtask

  // Histogram update, or expected read-out, for one accepted command beat
  task automatic hist_predict(input logic [1:0] op, input logic [PIX_W-1:0] r,
                              input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b,
                              input logic [BIN_AW-1:0] idx);
    int unsigned       luma_sum;
    logic [BIN_AW-1:0] sel;
    logic [COUNT_W-1:0] cnt;
    logic [63:0]       num;
    bin_readout_t      res;
    case (op)
      OP_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        hist_peak = '0;
      end
      OP_ACCUM: begin
        luma_sum = W_RED * r + W_GREEN * g + W_BLUE * b;
        case (hist_chan)
          CH_RED:   sel = r;
          CH_GREEN: sel = g;
          CH_BLUE:  sel = b;
          default:  sel = luma_sum[23:16];
        endcase
        cnt = hist_bins[sel];
        if (cnt != {COUNT_W{1'b1}}) cnt++;
        hist_bins[sel] = cnt;
        if (cnt > hist_peak) hist_peak = cnt;
        last_bin = sel;
      end
      OP_READ: begin
        cnt = hist_bins[idx];
        if (hist_peak == '0) begin
          res.norm = '0;
        end else if (cnt >= hist_peak) begin
          res.norm = NORM_ONE;
        end else begin
          num = 64'(cnt) << QUOT_W;
          res.norm = NORM_W'(num / 64'(hist_peak));
        end
        res.count = OUT_CW'(cnt);
        res.peak  = OUT_CW'(hist_peak);
        readouts_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  // One command beat, then, while gaps are on, an occasional gap between bursts
  task automatic send_cmd(input logic [1:0] op, input logic [PIX_W-1:0] r,
                          input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b,
                          input logic [BIN_AW-1:0] idx);
    @(negedge clk_i);
    start         <= 1'b1;
    op_i          <= op;
    pixel_red_i   <= r;
    pixel_green_i <= g;
    pixel_blue_i  <= b;
    bin_index_i   <= idx;
    do @(posedge clk_i); while (busy);
    hist_predict(op, r, g, b, idx);
    if (gaps_on) begin
      if (burst_left == 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic set_channel(input chan_e ch);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ch;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    hist_chan = ch;
  endtask

  task automatic accum(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                       input logic [PIX_W-1:0] b);
    send_cmd(OP_ACCUM, r, g, b, BIN_AW'($urandom));
  endtask

  task automatic read_bin(input logic [BIN_AW-1:0] idx);
    send_cmd(OP_READ, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), idx);
  endtask

  always @(posedge clk_i) begin : result_check
    bin_readout_t due;
    if (rst_ni && result_valid_o) begin
      if (readouts_due.size() == 0) begin
        flag_mismatch("unexpected result beat, bin_count", '0, bin_count_o);
      end else begin
        due = readouts_due.pop_front();
        if (due.norm !== norm_value_o)  flag_mismatch("norm_value", due.norm, norm_value_o);
        if (due.count !== bin_count_o)  flag_mismatch("bin_count", due.count, bin_count_o);
        if (due.peak !== peak_count_o)  flag_mismatch("peak_count", due.peak, peak_count_o);
      end
    end
  end

  task automatic test_after_reset();
    read_bin(8'h00);
    read_bin(8'hFF);
  endtask

  task automatic test_luma_weights();
    accum(8'h00, 8'h00, 8'h00);
    accum(8'hFF, 8'hFF, 8'hFF);
    accum(8'hFF, 8'h00, 8'h00);
    accum(8'h00, 8'hFF, 8'h00);
    accum(8'h00, 8'h00, 8'hFF);
    read_bin(8'd76);
    read_bin(8'hFF);
  endtask

  task automatic test_channel_select();
    set_channel(CH_RED);
    accum(8'd200, 8'd10, 8'd20);
    set_channel(CH_GREEN);
    accum(8'd200, 8'd10, 8'd20);
    set_channel(CH_BLUE);
    accum(8'd200, 8'd10, 8'd20);
    set_channel(CH_LUMA);
    read_bin(8'd200);
    read_bin(8'd10);
    read_bin(8'd20);
  endtask

  // fraction below one, exactly one, and an empty bin
  task automatic test_normalise();
    accum(8'hFF, 8'hFF, 8'hFF);
    accum(8'hFF, 8'hFF, 8'hFF);
    read_bin(8'hFF);
    read_bin(8'd76);
    read_bin(8'd5);
  endtask

  task automatic test_unused_op();
    send_cmd(OP_UNUSED, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
             BIN_AW'($urandom));
    read_bin(8'hFF);
  endtask

  task automatic test_clear();
    send_cmd(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    read_bin(8'hFF);
  endtask

  task automatic test_random();
    int   pick;
    chan_e phase_chan;
    logic [PIX_W-1:0] pix [3];
    for (int p = 0; p < PHASES; p++) begin
      phase_chan = (p < 4) ? chan_e'(p) : chan_e'($urandom_range(0, 3));
      set_channel(phase_chan);
      gaps_on = (p != 2);
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        pick = $urandom_range(0, 99);
        // skew half the pixels into a narrow band so a few bins grow tall
        foreach (pix[i])
          pix[i] = $urandom_range(0, 1) ? PIX_W'($urandom) : PIX_W'($urandom_range(120, 123));
        if (pick < 2)
          send_cmd(OP_UNUSED, pix[0], pix[1], pix[2], BIN_AW'($urandom));
        else if (pick < 5)
          send_cmd(OP_CLEAR, pix[0], pix[1], pix[2], BIN_AW'($urandom));
        else if (pick < 30)
          read_bin($urandom_range(0, 1) ? last_bin : BIN_AW'($urandom));
        else
          accum(pix[0], pix[1], pix[2]);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    op_i          = OP_CLEAR;
    pixel_red_i   = '0;
    pixel_green_i = '0;
    pixel_blue_i  = '0;
    bin_index_i   = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = CH_LUMA;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_peak  = '0;
    hist_chan  = CH_LUMA;
    last_bin   = '0;
    fail_count = 0;
    gaps_on    = 1'b1;
    burst_left = $urandom_range(1, 40);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_luma_weights();
    test_channel_select();
    test_normalise();
    test_unused_op();
    test_clear();
    test_random();

    wait_idle();
    if (readouts_due.size() != 0) begin
      fail_count += readouts_due.size();
      $display("%0d read-out beats never arrived", readouts_due.size());
    end
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
